// ===== hdl/itoa_pkg.sv =====
`default_nettype none

package itoa_pkg;

    localparam int VALUE_W  = 64;
    localparam int DIGIT_W  = 4;
    localparam int DEC_DIGS = 20;
    localparam int HEX_DIGS = 16;
    localparam int BCD_W    = DEC_DIGS * DIGIT_W;
    localparam int CNT_W    = $clog2(VALUE_W + 1);
    localparam int LEN_W    = 5;

    localparam logic [1:0] OP_UDEC = 2'd0;
    localparam logic [1:0] OP_SDEC = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_TRIM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic trim;
        logic take;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic lead_zero;
        logic last_char;
    } stat_t;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        if (d > 4'd9) begin
            c = CHAR_A + 8'(d - 4'd10);
        end else begin
            c = CHAR_ZERO + 8'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/itoa_ctrl.sv =====
`default_nettype none

module itoa_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           m_ready,
    input  wire itoa_pkg::stat_t stat,
    output itoa_pkg::cmd_t      cmd,
    output logic                s_ready,
    output logic                m_valid
);

    itoa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= itoa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            itoa_pkg::ST_IDLE: begin
                if (s_valid) state_next = itoa_pkg::ST_CONVERT;
            end
            itoa_pkg::ST_CONVERT: begin
                if (stat.conv_done) state_next = itoa_pkg::ST_TRIM;
            end
            itoa_pkg::ST_TRIM: begin
                if (!stat.lead_zero) state_next = itoa_pkg::ST_EMIT;
            end
            itoa_pkg::ST_EMIT: begin
                if (m_ready && stat.last_char) state_next = itoa_pkg::ST_IDLE;
            end
            default: state_next = itoa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            itoa_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            itoa_pkg::ST_CONVERT: begin
                cmd.dabble = !stat.conv_done;
            end
            itoa_pkg::ST_TRIM: begin
                cmd.trim = stat.lead_zero;
            end
            itoa_pkg::ST_EMIT: begin
                m_valid  = 1'b1;
                cmd.take = m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/itoa_dp.sv =====
`default_nettype none

module itoa_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire itoa_pkg::cmd_t                    cmd,
    input  wire logic [1:0]                        s_op,
    input  wire logic [itoa_pkg::VALUE_W-1:0]      s_value,
    output itoa_pkg::stat_t                        stat,
    output logic [7:0]                             m_character,
    output logic [itoa_pkg::LEN_W-1:0]             m_text_length,
    output logic                                   m_is_last
);

    localparam int TOP = itoa_pkg::BCD_W - itoa_pkg::DIGIT_W;

    logic [itoa_pkg::BCD_W-1:0]   digits_reg, digits_next;
    logic [itoa_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [itoa_pkg::CNT_W-1:0]   bits_reg, bits_next;
    logic [itoa_pkg::LEN_W-1:0]   ndig_reg, ndig_next;
    logic [itoa_pkg::LEN_W-1:0]   len_reg, len_next;
    logic                         sign_reg, sign_next;

    logic                         in_neg;
    logic                         in_hex;
    logic [itoa_pkg::VALUE_W-1:0] in_mag;
    logic [itoa_pkg::BCD_W-1:0]   adj;
    logic [itoa_pkg::LEN_W-1:0]   base_len;

    assign in_hex   = (s_op == itoa_pkg::OP_HEX);
    assign in_neg   = (s_op == itoa_pkg::OP_SDEC) && s_value[itoa_pkg::VALUE_W-1];
    assign in_mag   = in_neg ? (~s_value + 1'b1) : s_value;
    assign base_len = in_hex ? itoa_pkg::LEN_W'(itoa_pkg::HEX_DIGS)
                             : itoa_pkg::LEN_W'(itoa_pkg::DEC_DIGS);

    // add-3 correction on every bcd digit before the shift
    always_comb begin
        for (int i = 0; i < itoa_pkg::DEC_DIGS; i++) begin
            if (digits_reg[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] >= 4'd5) begin
                adj[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] =
                    digits_reg[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] + 4'd3;
            end else begin
                adj[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] =
                    digits_reg[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W];
            end
        end
    end

    always_comb begin
        digits_next = digits_reg;
        bin_next    = bin_reg;
        bits_next   = bits_reg;
        ndig_next   = ndig_reg;
        len_next    = len_reg;
        sign_next   = sign_reg;
        if (cmd.load) begin
            sign_next = in_neg;
            ndig_next = base_len;
            len_next  = base_len + itoa_pkg::LEN_W'(in_neg);
            bin_next  = in_mag;
            if (in_hex) begin
                // hex digits go straight in, left justified
                digits_next = {s_value,
                               {(itoa_pkg::BCD_W - itoa_pkg::VALUE_W){1'b0}}};
                bits_next   = '0;
            end else begin
                digits_next = '0;
                bits_next   = itoa_pkg::CNT_W'(itoa_pkg::VALUE_W);
            end
        end else if (cmd.dabble) begin
            digits_next = {adj[itoa_pkg::BCD_W-2:0], bin_reg[itoa_pkg::VALUE_W-1]};
            bin_next    = {bin_reg[itoa_pkg::VALUE_W-2:0], 1'b0};
            bits_next   = bits_reg - 1'b1;
        end else if (cmd.trim) begin
            digits_next = {digits_reg[TOP-1:0], {itoa_pkg::DIGIT_W{1'b0}}};
            ndig_next   = ndig_reg - 1'b1;
            len_next    = len_reg - 1'b1;
        end else if (cmd.take) begin
            if (sign_reg) begin
                sign_next = 1'b0;
            end else begin
                digits_next = {digits_reg[TOP-1:0], {itoa_pkg::DIGIT_W{1'b0}}};
                ndig_next   = ndig_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sign_reg <= 1'b0;
            ndig_reg <= '0;
            bits_reg <= '0;
        end else begin
            sign_reg <= sign_next;
            ndig_reg <= ndig_next;
            bits_reg <= bits_next;
        end
    end

    always_ff @(posedge aclk) begin
        digits_reg <= digits_next;
        bin_reg    <= bin_next;
        len_reg    <= len_next;
    end

    assign stat.conv_done = (bits_reg == '0);
    assign stat.lead_zero = (digits_reg[itoa_pkg::BCD_W-1:TOP] == '0)
                            && (ndig_reg > itoa_pkg::LEN_W'(1));
    assign stat.last_char = !sign_reg && (ndig_reg == itoa_pkg::LEN_W'(1));

    assign m_character   = sign_reg ? itoa_pkg::CHAR_MINUS
                                    : itoa_pkg::digit_char(digits_reg[itoa_pkg::BCD_W-1:TOP]);
    assign m_text_length = len_reg;
    assign m_is_last     = stat.last_char;

endmodule

`default_nettype wire

// ===== hdl/integer_to_ascii_formatter_core.sv =====
`default_nettype none

// channel   ports                                        direction
// input     s_valid s_ready s_op[1:0] s_value[63:0]      in (ready out)
// result    m_valid m_ready m_character[7:0]             out (ready in)
//           m_text_length[4:0] m_is_last
//
// one value at a time: the value is accepted in idle, then shifted through the
// binary-to-bcd converter in decimal modes (64 shift-add-3 steps, then the
// done check; hex digits load directly), then leading zero digits are dropped
// one at a time, then one character per cycle while m_ready is high, with
// m_ready stalls holding the output
// reset clears the controller to idle; m_ready low holds the current character

module integer_to_ascii_formatter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [63:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_character,
    output logic [4:0]       m_text_length,
    output logic             m_is_last
);

    itoa_pkg::cmd_t  cmd;
    itoa_pkg::stat_t stat;

    itoa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready),
        .m_valid (m_valid)
    );

    itoa_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_op          (s_op),
        .s_value       (s_value),
        .stat          (stat),
        .m_character   (m_character),
        .m_text_length (m_text_length),
        .m_is_last     (m_is_last)
    );

    // no new value while characters are still going out
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while emitting");

    // a minus sign is never the whole text
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_character == itoa_pkg::CHAR_MINUS) |-> !m_is_last)
        else $error("minus sign marked last");

    // text keeps flowing until the last character transfer
    a_text_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_is_last) |=> m_valid)
        else $error("text stopped before last character");

    // length stays fixed over one text
    a_len_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_last) |=> $stable(m_text_length))
        else $error("text length changed mid text");

endmodule

`default_nettype wire

// ===== dv/integer_to_ascii_formatter_core_test.sv =====
module integer_to_ascii_formatter_core_test;

    localparam logic [1:0] OP_RSVD = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic [7:0] character;
        logic [4:0] text_length;
        logic       is_last;
    } text_char_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic [63:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_character;
    logic [4:0]  m_text_length;
    logic        m_is_last;

    text_char_t pending_chars[$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    logic       no_idle = 1'b0;

    integer_to_ascii_formatter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_character   (m_character),
        .m_text_length (m_text_length),
        .m_is_last     (m_is_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // expected text of one value, most significant character first
    function automatic void predict_text(input logic [1:0] op, input logic [63:0] value);
        logic [7:0] digits [20];
        int         count;
        int         total;
        int         pos;
        logic       negative;
        logic [63:0] mag;
        logic [3:0] nib;
        text_char_t entry;
        count = 0;
        negative = 1'b0;
        mag = value;
        if (op == itoa_pkg::OP_HEX) begin
            do begin
                nib = mag[3:0];
                digits[count] = (nib > 4'd9) ? itoa_pkg::CHAR_A + 8'(nib - 4'd10)
                                             : itoa_pkg::CHAR_ZERO + 8'(nib);
                count++;
                mag = mag >> 4;
            end while (mag != 64'd0 && count < 16);
        end else begin
            if (op == itoa_pkg::OP_SDEC && mag[63]) begin
                negative = 1'b1;
                mag = 64'd0 - mag;
            end
            do begin
                digits[count] = itoa_pkg::CHAR_ZERO + 8'(mag % 64'd10);
                count++;
                mag = mag / 64'd10;
            end while (mag != 64'd0 && count < 20);
        end
        total = count + (negative ? 1 : 0);
        pos = 0;
        if (negative) begin
            entry.character = itoa_pkg::CHAR_MINUS;
            entry.text_length = 5'(total);
            entry.is_last = (total == 1);
            pending_chars.push_back(entry);
            pos++;
        end
        for (int i = count - 1; i >= 0; i--) begin
            entry.character = digits[i];
            entry.text_length = 5'(total);
            entry.is_last = (pos + 1 == total);
            pending_chars.push_back(entry);
            pos++;
        end
    endfunction

    // valid is only lowered for an idle gap, never between back-to-back transfers
    task automatic send_value(input logic [1:0] op, input logic [63:0] value);
        int gap;
        if (!no_idle && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_text(op, value);
    endtask

    task automatic wait_text_drained();
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] pow;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: ;
            1: v = v >> $urandom_range(63);
            2: v = ~(v >> $urandom_range(63));
            default: begin
                pow = 64'd1;
                repeat ($urandom_range(19)) pow = pow * 64'd10;
                v = pow + 64'($urandom_range(2)) - 64'd1;
            end
        endcase
        return v;
    endfunction

    function automatic logic [1:0] random_op();
        case ($urandom_range(9))
            0, 1, 2: return itoa_pkg::OP_UDEC;
            3, 4, 5: return itoa_pkg::OP_SDEC;
            6, 7, 8: return itoa_pkg::OP_HEX;
            default: return OP_RSVD;
        endcase
    endfunction

    task automatic test_directed();
        send_value(itoa_pkg::OP_UDEC, 64'd0);
        send_value(itoa_pkg::OP_SDEC, 64'd0);
        send_value(itoa_pkg::OP_HEX, 64'd0);
        send_value(OP_RSVD, 64'd0);
        send_value(OP_RSVD, 64'd1234567);
        send_value(itoa_pkg::OP_UDEC, 64'hffff_ffff_ffff_ffff);
        send_value(itoa_pkg::OP_SDEC, 64'hffff_ffff_ffff_ffff);
        send_value(itoa_pkg::OP_SDEC, 64'h8000_0000_0000_0000);
        send_value(itoa_pkg::OP_SDEC, 64'h7fff_ffff_ffff_ffff);
        send_value(itoa_pkg::OP_UDEC, 64'h8000_0000_0000_0000);
        send_value(itoa_pkg::OP_HEX, 64'hffff_ffff_ffff_ffff);
        send_value(itoa_pkg::OP_HEX, 64'h0123_4567_89ab_cdef);
        send_value(itoa_pkg::OP_HEX, 64'hf);
        send_value(itoa_pkg::OP_HEX, 64'h10);
        send_value(itoa_pkg::OP_UDEC, 64'd9);
        send_value(itoa_pkg::OP_UDEC, 64'd10);
        send_value(itoa_pkg::OP_SDEC, 64'hffff_ffff_ffff_fff6);
        send_value(itoa_pkg::OP_UDEC, 64'd10000000000000000000);
        send_value(itoa_pkg::OP_UDEC, 64'd9999999999999999999);
        send_value(itoa_pkg::OP_SDEC, 64'd1000000000000000000);
    endtask

    task automatic test_random_values(input int n);
        repeat (n) send_value(random_op(), random_value());
    endtask

    // no idling on either side for a while
    task automatic test_streaming(input int n);
        no_idle = 1'b1;
        repeat (n) send_value(random_op(), random_value());
        no_idle = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        send_value(itoa_pkg::OP_SDEC, random_value());
        wait_text_drained();
        send_value(itoa_pkg::OP_HEX, random_value());
    endtask

    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 38);
    end

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character %h, nothing pending", $time, m_character);
                mismatches++;
            end else begin
                want = pending_chars.pop_front();
                if (m_character !== want.character) begin
                    $display("%0t: character expected %h actual %h",
                             $time, want.character, m_character);
                    mismatches++;
                end
                if (m_text_length !== want.text_length) begin
                    $display("%0t: text_length expected %0d actual %0d",
                             $time, want.text_length, m_text_length);
                    mismatches++;
                end
                if (m_is_last !== want.is_last) begin
                    $display("%0t: is_last expected %b actual %b",
                             $time, want.is_last, m_is_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_op <= itoa_pkg::OP_UDEC;
        s_value <= 64'd0;
        m_ready <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_values(60);
        test_pause_until_drained();
        test_streaming(30);
        test_random_values(48);

        wait_text_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
